// ===== hdl/fair_queue_pipe_selector_top_macros.svh =====
`ifndef FAIR_QUEUE_PIPE_SELECTOR_TOP_MACROS_SVH
`define FAIR_QUEUE_PIPE_SELECTOR_TOP_MACROS_SVH

// same-cycle implication, checked on every clock while out of reset
`define FQPS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fqps check failed");

// implication whose consequent is checked at the next clock
`define FQPS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fqps check failed");

`endif

// ===== hdl/fqps_pkg.sv =====
`default_nettype none

package fqps_pkg;

	localparam int MAX_PIPES_DEF = 16;
	localparam int ID_W          = 4;
	localparam int N_IDS         = 16;

	typedef enum logic [2:0] {
		CMD_ADD        = 3'd0,
		CMD_REMOVE     = 3'd1,
		CMD_ACTIVATE   = 3'd2,
		CMD_DEACTIVATE = 3'd3,
		CMD_RECV       = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE   = 2'd0,
		ST_AGAIN  = 2'd1,
		ST_ERROR  = 2'd2,
		ST_REJECT = 2'd3
	} status_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_EXEC
	} fsm_t;

	typedef struct packed {
		logic [2:0]       cmd;
		logic [ID_W-1:0]  pipe_id;
		logic [N_IDS-1:0] recv_ok_mask;
		logic [N_IDS-1:0] recv_err_mask;
	} req_t;

	typedef struct packed {
		logic [1:0]      status;
		logic [ID_W-1:0] pipe_out;
		logic            any_active;
	} rsp_t;

	// search chain handed from cell to cell
	typedef struct packed {
		logic            found;
		logic            ok;
		logic [ID_W-1:0] id;
	} chain_t;

	// broadcast to every cell for the search and for an add
	typedef struct packed {
		logic             match_rm;
		logic [ID_W-1:0]  pipe_id;
		logic [N_IDS-1:0] act;
		logic [N_IDS-1:0] ok;
		logic [N_IDS-1:0] err;
	} cell_bus_t;

	// broadcast to every cell for the list update
	typedef struct packed {
		logic            add;
		logic            shift;
		logic            tail_take;
		logic [ID_W-1:0] tail_id;
	} upd_t;

endpackage

`default_nettype wire

// ===== hdl/fqps_chan_if.sv =====
`default_nettype none

interface fqps_chan_if #(
	parameter type data_t = logic
) ();
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/fqps_cell.sv =====
`default_nettype none

module fqps_cell #(
	parameter int IDX   = 0,
	parameter int CNT_W = 5
) (
	input  wire logic                         clk,
	input  wire logic [CNT_W-1:0]             count,
	input  wire fqps_pkg::cell_bus_t          bus,
	input  wire fqps_pkg::upd_t               upd,
	input  wire fqps_pkg::chain_t             chain_in,
	input  wire logic [fqps_pkg::ID_W-1:0]    nbr_id,
	output fqps_pkg::chain_t                  chain_out,
	output logic [fqps_pkg::ID_W-1:0]         id
);

	logic [fqps_pkg::ID_W-1:0] id_q;
	logic                      valid;
	logic                      is_last;
	logic                      sel;
	logic                      at_or_after;

	assign valid   = CNT_W'(IDX) < count;
	assign is_last = CNT_W'(IDX) == (count - CNT_W'(1));
	assign id      = id_q;

	always_comb begin
		if (bus.match_rm) begin
			sel = valid && (id_q == bus.pipe_id);
		end else begin
			sel = valid && bus.act[id_q] && (bus.ok[id_q] || bus.err[id_q]);
		end
	end

	assign at_or_after = chain_in.found || sel;

	always_comb begin
		chain_out = chain_in;
		if (!chain_in.found && sel) begin
			chain_out.found = 1'b1;
			chain_out.ok    = bus.ok[id_q];
			chain_out.id    = id_q;
		end
	end

	// cells from the hit onwards take their neighbour's id, the tail may take the grant
	always_ff @(posedge clk) begin
		if (upd.add && (CNT_W'(IDX) == count)) begin
			id_q <= bus.pipe_id;
		end else if (upd.shift && at_or_after) begin
			id_q <= (upd.tail_take && is_last) ? upd.tail_id : nbr_id;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/fair_queue_pipe_selector_top.sv =====
// round-robin fair-queue pipe selector
// req channel (valid/ready) carries cmd, pipe_id, recv_ok_mask and recv_err_mask;
// rsp channel carries status, pipe_out and any_active, one result per request.
// the pipe list lives in a row of cells, one list entry per cell. a search signal
// ripples along the row to find the entry to remove or the first active pipe that
// succeeds or errors; on a remove or a success the cells from that point shift one
// place towards the head, and a successful pipe moves to the tail. each request is
// first registered, then the list is updated after a single search through the row;
// a new request is taken only after the previous one has been executed.
// the result sits in an output register, so a new request can be taken while a
// result waits for its transfer. a stalled receiver holds the result and the block
// waits before executing the next request.
// at reset the list is empty, all pipes unlisted and inactive, no result pending.
`default_nettype none

module fair_queue_pipe_selector_top #(
	parameter int MAX_PIPES = fqps_pkg::MAX_PIPES_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	fqps_chan_if.sink   req,
	fqps_chan_if.source rsp
);

	localparam int CAP   = (MAX_PIPES < fqps_pkg::N_IDS) ? MAX_PIPES : fqps_pkg::N_IDS;
	localparam int CNT_W = $clog2(CAP + 1);

	fqps_pkg::fsm_t state_q, state_d;

	logic [2:0]                      cmd_q;
	logic [fqps_pkg::ID_W-1:0]       pipe_q;
	logic [fqps_pkg::N_IDS-1:0]      ok_q, err_q;
	logic [CNT_W-1:0]                count_q, count_d;
	logic [fqps_pkg::N_IDS-1:0]      member_q, member_d;
	logic [fqps_pkg::N_IDS-1:0]      active_q, active_d;
	logic [fqps_pkg::N_IDS-1:0]      bit_p;
	fqps_pkg::rsp_t                  rsp_q, rsp_d;
	logic                            rsp_valid_q;
	logic                            exec_fire;
	logic                            accept;
	fqps_pkg::cell_bus_t             bus;
	fqps_pkg::upd_t                  upd;
	fqps_pkg::chain_t                chain [CAP+1];
	logic [fqps_pkg::ID_W-1:0]       cell_id [CAP];

	assign accept    = req.valid && req.ready;
	assign exec_fire = (state_q == fqps_pkg::FSM_EXEC) && (!rsp_valid_q || rsp.ready);
	assign bit_p     = fqps_pkg::N_IDS'(1) << pipe_q;

	always_comb begin
		unique case (state_q)
			fqps_pkg::FSM_IDLE: state_d = accept ? fqps_pkg::FSM_EXEC : fqps_pkg::FSM_IDLE;
			fqps_pkg::FSM_EXEC: state_d = exec_fire ? fqps_pkg::FSM_IDLE : fqps_pkg::FSM_EXEC;
			default:            state_d = fqps_pkg::FSM_IDLE;
		endcase
	end

	always_comb begin
		req.ready = (state_q == fqps_pkg::FSM_IDLE);
		rsp.valid = rsp_valid_q;
		rsp.data  = rsp_q;
	end

	assign bus.match_rm = (cmd_q == fqps_pkg::CMD_REMOVE);
	assign bus.pipe_id  = pipe_q;
	assign bus.act      = active_q;
	assign bus.ok       = ok_q;
	assign bus.err      = err_q;

	assign chain[0] = '0;

	for (genvar i = 0; i < CAP; i++) begin : g_cell
		fqps_cell #(
			.IDX   (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk       (clk),
			.count     (count_q),
			.bus       (bus),
			.upd       (upd),
			.chain_in  (chain[i]),
			.nbr_id    (cell_id[(i == CAP-1) ? i : i+1]),
			.chain_out (chain[i+1]),
			.id        (cell_id[i])
		);
	end

	always_comb begin
		count_d          = count_q;
		member_d         = member_q;
		active_d         = active_q;
		upd              = '0;
		upd.tail_id      = chain[CAP].id;
		rsp_d            = '0;
		rsp_d.status     = fqps_pkg::ST_DONE;
		unique case (cmd_q)
			fqps_pkg::CMD_ADD: begin
				if ((member_q & bit_p) != '0 || count_q == CNT_W'(CAP)) begin
					rsp_d.status = fqps_pkg::ST_REJECT;
				end else begin
					upd.add  = 1'b1;
					count_d  = count_q + CNT_W'(1);
					member_d = member_q | bit_p;
					active_d = active_q & ~bit_p;
				end
			end
			fqps_pkg::CMD_REMOVE: begin
				if ((member_q & bit_p) != '0) begin
					upd.shift = chain[CAP].found;
					count_d   = count_q - CNT_W'(1);
					member_d  = member_q & ~bit_p;
				end
			end
			fqps_pkg::CMD_ACTIVATE:   active_d = active_q | bit_p;
			fqps_pkg::CMD_DEACTIVATE: active_d = active_q & ~bit_p;
			fqps_pkg::CMD_RECV: begin
				if (!chain[CAP].found) begin
					rsp_d.status = fqps_pkg::ST_AGAIN;
				end else if (chain[CAP].ok) begin
					upd.shift      = 1'b1;
					upd.tail_take  = 1'b1;
					rsp_d.pipe_out = chain[CAP].id;
				end else begin
					rsp_d.status   = fqps_pkg::ST_ERROR;
					rsp_d.pipe_out = chain[CAP].id;
				end
			end
			default: rsp_d.status = fqps_pkg::ST_REJECT;
		endcase
		rsp_d.any_active = (member_d & active_d) != '0;
		if (!exec_fire) begin
			upd.add   = 1'b0;
			upd.shift = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fqps_pkg::FSM_IDLE;
			count_q     <= '0;
			member_q    <= '0;
			active_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (exec_fire) begin
				count_q     <= count_d;
				member_q    <= member_d;
				active_q    <= active_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= req.data.cmd;
			pipe_q <= req.data.pipe_id;
			ok_q   <= req.data.recv_ok_mask;
			err_q  <= req.data.recv_err_mask;
		end
		if (exec_fire) begin
			rsp_q <= rsp_d;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/fqps_checker.sv =====
`default_nettype none
`include "fair_queue_pipe_selector_top_macros.svh"

module fqps_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      req_valid,
	input wire logic                      req_ready,
	input wire logic                      rsp_valid,
	input wire logic                      rsp_ready,
	input wire logic [1:0]                rsp_status,
	input wire logic [fqps_pkg::ID_W-1:0] rsp_pipe_out,
	input wire logic                      rsp_any_active
);

	// a stalled result keeps its contents
	`FQPS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_pipe_out) && $stable(rsp_status))

	// one request in execution at a time
	`FQPS_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready)

	// no pipe reported for again or reject
	`FQPS_ASSERT_NOW(a_pipe_zero, rsp_valid && (rsp_status == fqps_pkg::ST_AGAIN || rsp_status == fqps_pkg::ST_REJECT), rsp_pipe_out == '0)

	// an error comes only from an active listed pipe, which stays so
	`FQPS_ASSERT_NOW(a_err_active, rsp_valid && rsp_status == fqps_pkg::ST_ERROR, rsp_any_active)

endmodule

bind fair_queue_pipe_selector_top fqps_checker u_fqps_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_status     (rsp.data.status),
	.rsp_pipe_out   (rsp.data.pipe_out),
	.rsp_any_active (rsp.data.any_active)
);

`default_nettype wire
